[rtl/core/masked_sample_statistics_assert.svh]
// assertion macros for the masked sample statistics checker
// expects clk and rst in the scope where a macro is used
`ifndef MASKED_SAMPLE_STATISTICS_ASSERT_SVH
`define MASKED_SAMPLE_STATISTICS_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mss_pkg.sv]
// shared types and constants for the masked sample statistics block
// no dependencies
`timescale 1ns / 1ps

package mss_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 17;
  localparam int SUM_W       = 33;
  localparam int SQSUM_W     = 47;
  localparam int MEAN_W      = 24;
  localparam int SD_W        = 23;
  localparam int FRAC_W      = 8;
  localparam int MAX_SAMPLES = 65536;

  localparam int ALU_W  = 64;
  localparam int MAG_W  = 32;
  localparam int ROOT_W = 32;
  localparam int DIV_W  = MAG_W + FRAC_W;
  localparam int CNT_W  = 6;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SD_W-1:0]            SD_MAX     = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_N,
    ST_MUL_M,
    ST_DIFF,
    ST_SQRT,
    ST_DIV_SD,
    ST_DIV_MEAN,
    ST_MEAN_FIX,
    ST_OUT
  } state_t;

endpackage

[rtl/core/masked_sample_statistics.sv]
// top level of the masked sample statistics block: accumulators and the
// sequenced closing arithmetic on one shared 64-bit adder; uses mss_pkg
`timescale 1ns / 1ps

// Masked sample statistics. Signed 16-bit samples stream in one item per
// cycle while sample_stall is low; a sample equal to exclude_value is
// skipped, the rest update a running min, max, count, sum and sum of squares
// (count saturates at MAX_SAMPLES). The item with last set closes the set
// and yields one result: min, max, mean = floor(S1*256/n) and std_dev =
// floor(isqrt(n*S2-S1^2)*256/n), both with 8 fraction bits; an empty set
// gives valid_res = 0 and all zeros. Rate: items without last are taken
// every cycle. A closing item is taken, then the block stalls while it
// updates, takes |S1|, shift-add multiplies n*S2 and S1^2, subtracts, runs
// the root steps, two restoring divides and a rounding step; an empty set
// goes from the |S1| step to the result. All closing work runs on one
// 64-bit add/compare unit. The input stays stalled until the result is
// taken, after which the accumulators clear for the next set. exclude_value
// may be written any time the block is idle; cfg_ready is always high.
module masked_sample_statistics (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] exclude_value,
  // sample items
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  // result items
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                valid_res,
  output logic signed [mss_pkg::SAMPLE_W-1:0] minimum,
  output logic signed [mss_pkg::SAMPLE_W-1:0] maximum,
  output logic signed [mss_pkg::MEAN_W-1:0]   mean,
  output logic        [mss_pkg::SD_W-1:0]     std_dev,
  output logic        [mss_pkg::COUNT_W-1:0]  counted
);
  import mss_pkg::*;

  state_t state, state_next;

  // exclusion register
  logic signed [SAMPLE_W-1:0] excl_value;

  // one-item holding stage in front of the accumulators
  logic                       acc_v;
  logic                       acc_last;
  logic signed [SAMPLE_W-1:0] acc_sample;

  // running set statistics
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic        [COUNT_W-1:0]  sample_count;
  logic signed [SUM_W-1:0]    sample_sum;
  logic        [SQSUM_W-1:0]  square_sum;

  // closing arithmetic working registers
  logic [ALU_W-1:0]  work_a;   // n*S2, then radicand, then remainder
  logic [ALU_W-1:0]  work_b;   // S1^2, then root
  logic [ALU_W-1:0]  shreg;    // root bit, then dividend / quotient
  logic [MAG_W-1:0]  mag;      // |S1|
  logic [CNT_W-1:0]  cnt;
  logic [SD_W-1:0]   sd_val;
  logic [MEAN_W-1:0] mean_val;

  // shared adder: a + (b or ~b) + cin, carry out doubles as a >= b
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_inv;
  logic             alu_cin;
  logic [ALU_W:0]   alu_sum;
  logic             alu_carry;

  logic                  in_take;
  logic                  upd;
  logic                  counts;
  logic signed [31:0]    sq_s;
  logic                  sum_neg;
  logic                  cnt_done;
  logic [ALU_W-1:0]      rem_shift;
  logic [DIV_W-1:0]      quot;
  logic [ALU_W-1:0]      rem_next;
  logic [ALU_W-1:0]      root_next;
  logic                  nonempty;

  assign cfg_ready = 1'b1;
  assign in_take   = sample_valid && !sample_stall;
  assign upd       = (state == ST_IDLE) && acc_v;
  assign counts    = (acc_sample != excl_value) &&
                     (sample_count < COUNT_W'(MAX_SAMPLES));
  assign sq_s      = 32'(acc_sample) * 32'(acc_sample);
  assign sum_neg   = sample_sum[SUM_W-1];
  assign cnt_done  = (cnt == '0);
  assign nonempty  = (sample_count != '0);

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_inv ? ~alu_b : alu_b)} +
                     {{ALU_W{1'b0}}, alu_cin};
  assign alu_carry = alu_sum[ALU_W];

  // restoring divide step: bring down the next dividend bit
  assign rem_shift = {work_a[ALU_W-2:0], shreg[DIV_W-1]};
  assign quot      = {shreg[DIV_W-2:0], alu_carry};
  assign rem_next  = alu_carry ? alu_sum[ALU_W-1:0] : rem_shift;

  // root after the current step
  assign root_next = alu_carry ? ((work_b >> 1) | shreg) : (work_b >> 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc_v && acc_last) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = nonempty ? ST_MUL_N : ST_OUT;
      end
      ST_MUL_N: begin
        if (cnt_done) state_next = ST_MUL_M;
      end
      ST_MUL_M: begin
        if (cnt_done) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_done) state_next = ST_DIV_SD;
      end
      ST_DIV_SD: begin
        if (cnt_done) state_next = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (cnt_done) state_next = ST_MEAN_FIX;
      end
      ST_MEAN_FIX: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!result_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // handshake and shared-unit controls
  always_comb begin
    sample_stall = !((state == ST_IDLE) && !(acc_v && acc_last));
    result_valid = (state == ST_OUT);
    alu_a        = '0;
    alu_b        = '0;
    alu_inv      = 1'b0;
    alu_cin      = 1'b0;
    case (state)
      ST_PREP: begin
        // magnitude of the sum
        alu_b   = ALU_W'(sample_sum);
        alu_inv = sum_neg;
        alu_cin = sum_neg;
      end
      ST_MUL_N: begin
        alu_a = {work_a[ALU_W-2:0], 1'b0};
        alu_b = sample_count[cnt[4:0]] ? ALU_W'(square_sum) : '0;
      end
      ST_MUL_M: begin
        alu_a = {work_b[ALU_W-2:0], 1'b0};
        alu_b = mag[cnt[4:0]] ? ALU_W'(mag) : '0;
      end
      ST_DIFF: begin
        alu_a   = work_a;
        alu_b   = work_b;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_SQRT: begin
        // root and trial bit never overlap, so or is the sum
        alu_a   = work_a;
        alu_b   = work_b | shreg;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_DIV_SD, ST_DIV_MEAN: begin
        alu_a   = rem_shift;
        alu_b   = ALU_W'(sample_count);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_MEAN_FIX: begin
        // -(q + (rem != 0)) for a negative sum
        alu_b   = ALU_W'(shreg[DIV_W-1:0]);
        alu_inv = 1'b1;
        alu_cin = (work_a == '0);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc_v      <= 1'b0;
      excl_value <= '0;
    end else begin
      state <= state_next;
      acc_v <= in_take;
      if (cfg_valid && cfg_ready) excl_value <= exclude_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      acc_sample <= sample;
      acc_last   <= last;
    end
  end

  // accumulators, cleared at reset and once the result is taken
  always_ff @(posedge clk) begin
    if (rst || ((state == ST_OUT) && !result_stall)) begin
      run_min      <= SAMPLE_MAX;
      run_max      <= SAMPLE_MIN;
      sample_count <= '0;
      sample_sum   <= '0;
      square_sum   <= '0;
    end else if (upd && counts) begin
      if (acc_sample < run_min) run_min <= acc_sample;
      if (acc_sample > run_max) run_max <= acc_sample;
      sample_count <= sample_count + COUNT_W'(1);
      sample_sum   <= sample_sum + SUM_W'(acc_sample);
      square_sum   <= square_sum + SQSUM_W'(unsigned'(sq_s));
    end
  end

  // closing datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        mag    <= alu_sum[MAG_W-1:0];
        work_a <= '0;
        work_b <= '0;
        cnt    <= CNT_W'(COUNT_W - 1);
      end
      ST_MUL_N: begin
        work_a <= alu_sum[ALU_W-1:0];
        cnt    <= cnt_done ? CNT_W'(MAG_W - 1) : cnt - CNT_W'(1);
      end
      ST_MUL_M: begin
        work_b <= alu_sum[ALU_W-1:0];
        cnt    <= cnt - CNT_W'(1);
      end
      ST_DIFF: begin
        // n*S2 - S1^2, floored at zero
        work_a <= alu_carry ? alu_sum[ALU_W-1:0] : '0;
        work_b <= '0;
        shreg  <= {2'b01, {(ALU_W-2){1'b0}}};
        cnt    <= CNT_W'(ROOT_W - 1);
      end
      ST_SQRT: begin
        if (cnt_done) begin
          // last root step; load root*256 as the dividend
          work_a <= '0;
          shreg  <= {{(ALU_W-DIV_W){1'b0}}, root_next[ROOT_W-1:0], {FRAC_W{1'b0}}};
          cnt    <= CNT_W'(DIV_W - 1);
        end else begin
          if (alu_carry) work_a <= alu_sum[ALU_W-1:0];
          work_b <= root_next;
          shreg  <= shreg >> 2;
          cnt    <= cnt - CNT_W'(1);
        end
      end
      ST_DIV_SD: begin
        if (cnt_done) begin
          sd_val <= (quot > DIV_W'(SD_MAX)) ? SD_MAX : quot[SD_W-1:0];
          work_a <= '0;
          shreg  <= ALU_W'({mag, {FRAC_W{1'b0}}});
          cnt    <= CNT_W'(DIV_W - 1);
        end else begin
          work_a <= rem_next;
          shreg  <= ALU_W'(quot);
          cnt    <= cnt - CNT_W'(1);
        end
      end
      ST_DIV_MEAN: begin
        work_a <= rem_next;
        shreg  <= ALU_W'(quot);
        cnt    <= cnt - CNT_W'(1);
      end
      ST_MEAN_FIX: begin
        mean_val <= sum_neg ? alu_sum[MEAN_W-1:0] : shreg[MEAN_W-1:0];
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // result fields, zero for an empty set
  assign valid_res = nonempty;
  assign minimum   = nonempty ? run_min : '0;
  assign maximum   = nonempty ? run_max : '0;
  assign mean      = nonempty ? mean_val : '0;
  assign std_dev   = nonempty ? sd_val : '0;
  assign counted   = sample_count;

endmodule

[rtl/core/mss_checker.sv]
// port-level checks for masked_sample_statistics and the bind that attaches them
// uses mss_pkg and masked_sample_statistics_assert.svh
`timescale 1ns / 1ps

`include "masked_sample_statistics_assert.svh"

module mss_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic signed [mss_pkg::SAMPLE_W-1:0] exclude_value,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic signed [mss_pkg::SAMPLE_W-1:0] sample,
  input logic                                last,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic                                valid_res,
  input logic signed [mss_pkg::SAMPLE_W-1:0] minimum,
  input logic signed [mss_pkg::SAMPLE_W-1:0] maximum,
  input logic signed [mss_pkg::MEAN_W-1:0]   mean,
  input logic        [mss_pkg::SD_W-1:0]     std_dev,
  input logic        [mss_pkg::COUNT_W-1:0]  counted
);

  // a stalled result stays offered
  `MSS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")

  // no new item is taken while a result waits
  `MSS_ASSERT_NOW(a_input_blocked, result_valid, sample_stall, "input taken while result pending")

  // an empty set reports all zeros
  `MSS_ASSERT_NOW(a_empty_zero, result_valid && !valid_res, (minimum == '0) && (maximum == '0) && (mean == '0) && (std_dev == '0) && (counted == '0), "empty set gave nonzero fields")

  // a counted set has a nonzero count and ordered extremes
  `MSS_ASSERT_NOW(a_set_order, result_valid && valid_res, (counted != '0) && (minimum <= maximum), "bad count or min above max")

endmodule

bind masked_sample_statistics mss_checker u_mss_checker (.*);
